FILE: rtl/assert_macros.svh
// Assertion macros shared by the step search RTL.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every rising edge, disabled during reset.
`define CHK_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication.
`define CHK_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

FILE: rtl/dmss_pkg.sv
// Package for the depth map step search: sizes, codes, state and command types.
// No dependencies.
package dmss_pkg;
  localparam int MaxRows = 256;
  localparam int MaxCols = 1024;
  localparam int CoordBits = 24;
  localparam int RowW = 8;
  localparam int ColW = 10;
  localparam int AddrW = RowW + ColW;
  localparam int DiffW = CoordBits + 1;
  localparam int SqW = 2 * DiffW;
  localparam int SumW = SqW + 2;

  localparam logic [2:0] RegMinStep = 3'd0;
  localparam logic [2:0] RegMaxStep = 3'd1;
  localparam logic [2:0] RegZeroRad = 3'd2;
  localparam logic [2:0] RegRows = 3'd3;
  localparam logic [2:0] RegCols = 3'd4;

  localparam logic [1:0] DirUp = 2'd0;
  localparam logic [1:0] DirDown = 2'd1;
  localparam logic [1:0] DirLeft = 2'd2;
  localparam logic [1:0] DirRight = 2'd3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD_CUR,
    ST_CUR,
    ST_RD_STEP,
    ST_EVAL,
    ST_DONE
  } state_t;

  // Controller to datapath.
  typedef struct packed {
    logic load;     // capture query
    logic rd_cur;   // read queried pixel
    logic cap_cur;  // latch queried pixel
    logic rd_step;  // read pixel at current step
    logic eval;     // evaluate step
    logic fin;      // present result
  } dp_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic outside;  // queried pixel outside the image
    logic cur_empty;
    logic no_budget;  // left or right walk with no column steps
    logic at_end;   // walk ended during the evaluation
  } dp_stat_t;
endpackage

FILE: rtl/depth_map_step_search_top.sv
// Top level of the depth map step search: config registers, controller, datapath.
// Depends on dmss_pkg, dmss_ctrl and dmss_datapath.
//
//   channel   ports                        handshake
//   input     start/busy, in_*             start && !busy
//   result    out_valid, out_step_*        out_valid, one cycle
//   config    cfg_we, cfg_index, cfg_data  cfg_we
//
// A query goes through load, read of the queried pixel, capture, then step
// evaluation and step read in turn over the single memory read port, and the
// result; a query outside the image ends after the read, an empty queried point
// or a left or right query with no column budget after the capture.
// Reset clears control and config only; the point memory keeps its content.
// The result strobe lasts one cycle and cannot be stalled.
module depth_map_step_search_top (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic               in_kind,
  input  logic [7:0]         in_row,
  input  logic [9:0]         in_col,
  input  logic signed [23:0] in_point_x,
  input  logic signed [23:0] in_point_y,
  input  logic signed [23:0] in_point_z,
  input  logic [15:0]        in_heading,
  input  logic [1:0]         in_direction,
  output logic               out_valid,
  output logic [7:0]         out_step_row,
  output logic [9:0]         out_step_col,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [22:0]        cfg_data
);
  logic [22:0] min_step_r, max_step_r;
  logic [15:0] zero_radius_r;
  logic [8:0] rows_r;
  logic [10:0] cols_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_step_r <= '0;
      max_step_r <= 23'd4096;
      zero_radius_r <= 16'd41;
      rows_r <= 9'd256;
      cols_r <= 11'd1024;
    end else if (cfg_we) begin
      case (cfg_index)
        dmss_pkg::RegMinStep: min_step_r <= cfg_data;
        dmss_pkg::RegMaxStep: max_step_r <= cfg_data;
        dmss_pkg::RegZeroRad: zero_radius_r <= cfg_data[15:0];
        dmss_pkg::RegRows: rows_r <= cfg_data[8:0];
        dmss_pkg::RegCols: cols_r <= cfg_data[10:0];
        default: ;
      endcase
    end
  end

  dmss_pkg::dp_cmd_t cmd;
  dmss_pkg::dp_stat_t stat;
  logic wr_en;

  dmss_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .start(start), .in_kind(in_kind),
    .busy(busy), .wr_en(wr_en), .out_valid(out_valid), .cmd(cmd), .stat(stat)
  );

  dmss_datapath u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .stat(stat), .wr_en(wr_en),
    .in_row(in_row), .in_col(in_col), .in_point_x(in_point_x),
    .in_point_y(in_point_y), .in_point_z(in_point_z), .in_heading(in_heading),
    .in_direction(in_direction), .min_step(min_step_r), .max_step(max_step_r),
    .zero_radius(zero_radius_r), .rows_in_use(rows_r), .cols_in_use(cols_r),
    .out_step_row(out_step_row), .out_step_col(out_step_col)
  );
endmodule

FILE: rtl/dmss_datapath.sv
// Datapath of the step search: point memory, walk position and distance checks.
// Depends on dmss_pkg and assert_macros.svh.
`include "assert_macros.svh"
module dmss_datapath (
  input  logic                        clk,
  input  logic                        rst_n,
  input  dmss_pkg::dp_cmd_t           cmd,
  output dmss_pkg::dp_stat_t          stat,
  input  logic                        wr_en,
  input  logic [dmss_pkg::RowW-1:0]   in_row,
  input  logic [dmss_pkg::ColW-1:0]   in_col,
  input  logic signed [23:0]          in_point_x,
  input  logic signed [23:0]          in_point_y,
  input  logic signed [23:0]          in_point_z,
  input  logic [15:0]                 in_heading,
  input  logic [1:0]                  in_direction,
  input  logic [22:0]                 min_step,
  input  logic [22:0]                 max_step,
  input  logic [15:0]                 zero_radius,
  input  logic [8:0]                  rows_in_use,
  input  logic [10:0]                 cols_in_use,
  output logic [dmss_pkg::RowW-1:0]   out_step_row,
  output logic [dmss_pkg::ColW-1:0]   out_step_col
);
  localparam int CB = dmss_pkg::CoordBits;
  localparam int PW = 3 * CB + 16;

  logic [PW-1:0] mem [dmss_pkg::MaxRows * dmss_pkg::MaxCols];
  logic [PW-1:0] rd_data_r;
  logic [dmss_pkg::AddrW-1:0] rd_addr;

  logic [dmss_pkg::RowW-1:0] row_r, rr_r;
  logic [dmss_pkg::ColW-1:0] col_r, rc_r;
  logic [1:0] dir_r;
  logic [10:0] s_r, lim_r;
  logic [8:0] rows_r;
  logic [10:0] cols_r;
  logic signed [CB-1:0] cx_r, cy_r, cz_r;
  logic [15:0] ch_r;
  logic [dmss_pkg::RowW-1:0] sh_r;   // row at current step
  logic [dmss_pkg::ColW-1:0] sc_r, pc_r;   // column at current and previous step

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[{in_row, in_col}] <= {in_point_x[CB-1:0], in_point_y[CB-1:0],
                                in_point_z[CB-1:0], in_heading};
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_addr = cmd.rd_cur ? {row_r, col_r} :
                   (dir_r[1] ? {row_r, sc_r} : {sh_r, col_r});

  logic signed [CB-1:0] vx, vy, vz;
  logic [15:0] vh;
  assign {vx, vy, vz, vh} = rd_data_r;

  function automatic logic [dmss_pkg::SqW-1:0] sqd(logic signed [CB-1:0] a,
                                                   logic signed [CB-1:0] b);
    logic signed [dmss_pkg::DiffW-1:0] d;
    logic [dmss_pkg::DiffW-1:0] m;
    d = dmss_pkg::DiffW'(a) - dmss_pkg::DiffW'(b);
    m = d[dmss_pkg::DiffW-1] ? dmss_pkg::DiffW'(-d) : dmss_pkg::DiffW'(d);
    return m * m;
  endfunction

  logic [dmss_pkg::SumW-1:0] norm2, dist2, zr2, mn2, mx2;
  assign norm2 = dmss_pkg::SumW'(sqd(vx, '0)) + dmss_pkg::SumW'(sqd(vy, '0))
               + dmss_pkg::SumW'(sqd(vz, '0));
  assign dist2 = dmss_pkg::SumW'(sqd(cx_r, vx)) + dmss_pkg::SumW'(sqd(cy_r, vy))
               + (dir_r[1] ? '0 : dmss_pkg::SumW'(sqd(cz_r, vz)));
  assign zr2 = dmss_pkg::SumW'(zero_radius * zero_radius);
  assign mn2 = dmss_pkg::SumW'(min_step * min_step);
  assign mx2 = dmss_pkg::SumW'(max_step * max_step);

  logic v_empty, far, reach, head_ok;
  logic [15:0] dt;
  assign v_empty = norm2 < zr2;
  assign far = dist2 > mx2;
  assign reach = dist2 >= mn2;
  assign dt = ch_r - vh;
  assign head_ok = (dir_r == dmss_pkg::DirRight) ? (dt <= 16'd32768)
                 : (dt == 16'd0 || dt > 16'd32768);

  logic [8:0] rows_eff;
  logic [10:0] cols_eff;
  assign rows_eff = (rows_in_use == 9'd0) ? 9'd1 :
                    (rows_in_use > 9'(dmss_pkg::MaxRows)) ? 9'(dmss_pkg::MaxRows) : rows_in_use;
  assign cols_eff = (cols_in_use == 11'd0) ? 11'd1 :
                    (cols_in_use > 11'(dmss_pkg::MaxCols)) ? 11'(dmss_pkg::MaxCols) : cols_in_use;

  // Column budget is cols / 3, taken as cols * 683 / 2048, which is exact up to 1024.
  logic [20:0] lim_prod;
  assign lim_prod = 21'(cols_eff) * 21'd683;

  // Next column along the walk, wrapped.
  logic [10:0] nc;
  always_comb begin
    if (dir_r == dmss_pkg::DirRight) begin
      nc = (11'(sc_r) + 11'd1 >= cols_r) ? 11'd0 : 11'(sc_r) + 11'd1;
    end else begin
      nc = (sc_r == '0) ? cols_r - 11'd1 : 11'(sc_r) - 11'd1;
    end
  end

  logic end_nxt;
  logic ud_edge;
  assign ud_edge = (dir_r == dmss_pkg::DirDown) ? (9'(sh_r) + 9'd1 >= rows_r)
                                               : (sh_r == '0);

  always_comb begin
    end_nxt = 1'b0;
    if (s_r != '0 && v_empty) begin
      end_nxt = 1'b1;
    end else if (!dir_r[1]) begin
      end_nxt = far || reach || ud_edge;
    end else begin
      end_nxt = (head_ok && (far || reach)) || (s_r + 11'd1 >= lim_r);
    end
  end

  logic at_end_r;
  assign stat.at_end = at_end_r;
  assign stat.outside = (9'(row_r) >= rows_r) || (11'(col_r) >= cols_r);
  assign stat.cur_empty = v_empty;
  assign stat.no_budget = dir_r[1] && (lim_r == '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      at_end_r <= 1'b0;
    end else begin
      at_end_r <= cmd.eval ? end_nxt : 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      row_r <= in_row;
      col_r <= in_col;
      dir_r <= in_direction;
      rr_r <= in_row;
      rc_r <= in_col;
      sh_r <= in_row;
      sc_r <= in_col;
      pc_r <= in_col;
      s_r <= '0;
      rows_r <= rows_eff;
      cols_r <= cols_eff;
      lim_r <= {1'b0, lim_prod[20:11]};
    end
    if (cmd.cap_cur) begin
      cx_r <= vx;
      cy_r <= vy;
      cz_r <= vz;
      ch_r <= vh;
      // A zero step budget leaves the queried pixel as the result.
    end
    if (cmd.eval) begin
      if (!dir_r[1]) begin
        rr_r <= sh_r;
        if (s_r != '0 && v_empty) begin
          rr_r <= (dir_r == dmss_pkg::DirDown) ? sh_r - 1'b1 : sh_r + 1'b1;
        end else if (far) begin
          if (s_r >= 11'd2) begin
            rr_r <= (dir_r == dmss_pkg::DirDown) ? sh_r - 1'b1 : sh_r + 1'b1;
          end
        end
        sh_r <= (dir_r == dmss_pkg::DirDown) ? sh_r + 1'b1 : sh_r - 1'b1;
      end else begin
        rc_r <= sc_r;
        if (s_r != '0 && v_empty) begin
          rc_r <= pc_r;
        end else if (head_ok && far && s_r > 11'd1) begin
          rc_r <= pc_r;
        end
        pc_r <= sc_r;
        sc_r <= nc[dmss_pkg::ColW-1:0];
      end
      s_r <= s_r + 11'd1;
    end
  end

  assign out_step_row = rr_r;
  assign out_step_col = rc_r;

  `CHK_IMPL(a_eval_inside, clk, rst_n, cmd.eval, !stat.outside,
            "step evaluated for a query outside the image")
  `CHK_NEXT(a_load_step0, clk, rst_n, cmd.load, s_r == '0,
            "step count not cleared at query load")
  `CHK_IMPL(a_excl_rd, clk, rst_n, cmd.rd_cur, !cmd.rd_step,
            "two memory reads commanded at once")
endmodule

FILE: rtl/dmss_ctrl.sv
// Controller of the step search: memory writes, reads and step checks.
// Depends on dmss_pkg and assert_macros.svh.
`include "assert_macros.svh"
module dmss_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic                in_kind,
  output logic                busy,
  output logic                wr_en,
  output logic                out_valid,
  output dmss_pkg::dp_cmd_t   cmd,
  input  dmss_pkg::dp_stat_t  stat
);
  dmss_pkg::state_t state_r, state_nxt;
  logic go;
  assign go = start && !busy;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      dmss_pkg::ST_IDLE: begin
        if (go && in_kind) state_nxt = dmss_pkg::ST_RD_CUR;
      end
      dmss_pkg::ST_RD_CUR: begin
        state_nxt = stat.outside ? dmss_pkg::ST_DONE : dmss_pkg::ST_CUR;
      end
      dmss_pkg::ST_CUR: begin
        state_nxt = (stat.cur_empty || stat.no_budget) ? dmss_pkg::ST_DONE
                                                        : dmss_pkg::ST_EVAL;
      end
      dmss_pkg::ST_RD_STEP: begin
        state_nxt = stat.at_end ? dmss_pkg::ST_DONE : dmss_pkg::ST_EVAL;
      end
      dmss_pkg::ST_EVAL: state_nxt = dmss_pkg::ST_RD_STEP;
      dmss_pkg::ST_DONE: state_nxt = dmss_pkg::ST_IDLE;
      default: state_nxt = dmss_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    busy = state_r != dmss_pkg::ST_IDLE;
    wr_en = go && !in_kind;
    out_valid = state_r == dmss_pkg::ST_DONE;
    case (state_r)
      dmss_pkg::ST_IDLE: cmd.load = go && in_kind;
      dmss_pkg::ST_RD_CUR: cmd.rd_cur = 1'b1;
      dmss_pkg::ST_CUR: cmd.cap_cur = 1'b1;
      dmss_pkg::ST_EVAL: cmd.eval = 1'b1;
      dmss_pkg::ST_RD_STEP: cmd.rd_step = 1'b1;
      dmss_pkg::ST_DONE: cmd.fin = 1'b1;
      default: cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= dmss_pkg::ST_IDLE;
    else state_r <= state_nxt;
  end

  `CHK_NEXT(a_done_idle, clk, rst_n, state_r == dmss_pkg::ST_DONE,
            state_r == dmss_pkg::ST_IDLE, "result state lasted more than one cycle")
  `CHK_IMPL(a_no_wr_busy, clk, rst_n, wr_en, !busy, "write while a query is running")
  `CHK_NEXT(a_query_starts, clk, rst_n, cmd.load, state_r == dmss_pkg::ST_RD_CUR,
            "accepted query did not start a read")
endmodule
